// ===== rtl/abm_pkg.sv =====
// Package for the air band saturation mixer: sizes, codes, the sequencer
// control word and the saturation helper. Depends on nothing.
`default_nettype none

package abm_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 32;
  localparam int GAIN_BITS     = 24;
  localparam int MIX_BITS      = 16;
  localparam int CHANNELS      = 2;
  localparam int CH_BITS       = 1;
  localparam int MA_BITS       = COEF_BITS;
  localparam int MB_BITS       = SAMPLE_BITS + 1;
  localparam int PROD_BITS     = MA_BITS + MB_BITS;
  localparam int ACC_BITS      = 60;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int COEF_FRAC     = 30;
  localparam int MIX_FRAC      = 20;
  localparam int WET_SHIFT     = 4;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1048576);
  localparam logic signed [ACC_BITS-1:0] RND_FILT = ACC_BITS'(64'd1 << (COEF_FRAC - 1));
  localparam logic signed [ACC_BITS-1:0] RND_MIX  = ACC_BITS'(64'd1 << (MIX_FRAC - 1));
  localparam logic signed [ACC_BITS-1:0] SAT_HI   =
    ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO   = -SAT_HI - ACC_BITS'(1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_B0, CFG_B1, CFG_B2, CFG_A1, CFG_A2, CFG_DRY, CFG_WET
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_B0X, OP_B1X1, OP_B2X2, OP_A1Y1, OP_A2Y2, OP_XG, OP_YY, OP_SW
  } op_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_FILT_INIT, ACC_ADD, ACC_SUB, ACC_MIX_INIT, ACC_ADD_WET
  } acc_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_B0, ST_B1, ST_B2, ST_A1, ST_A2, ST_XG, ST_Y, ST_YY,
    ST_SH, ST_SW, ST_MIX, ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    op_e  op;
    acc_e acc;
    logic ld_y;
    logic hist_we;
    logic ld_shaped;
    logic ld_out;
  } ctrl_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SAMPLE_BITS-1:0] y1;
    logic signed [SAMPLE_BITS-1:0] y2;
  } hist_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/air_band_saturation_mixer_top.sv =====
// Top level of the air band saturation mixer: ties sequencer, datapath and
// channel history together. Depends on abm_pkg, abm_seq, abm_dp and abm_hist.
//
// Each sample runs through a per-channel biquad, the shaper y + y*y/2 and
// the dry/wet mix, and leaves saturated to 24 bits. One 32 x 25 bit
// multiplier does all eight products in turn, so the input stays stalled
// from the transfer of a sample until the loading of the output register,
// and the next sample can be taken only after that. A new sample is taken
// while the previous result still waits at the output; its result is held
// back only while that earlier result has not been transferred.
`default_nettype none

module air_band_saturation_mixer_top
  import abm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [CH_BITS-1:0]            chan_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o
);

  ctrl_t                         ctrl;
  hist_t                         hist;
  logic signed [SAMPLE_BITS-1:0] x_cur, y_cur;

  assign cfg_ready_o = 1'b1;

  abm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  abm_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .chan_i  (chan_i),
    .x_new_i (x_cur),
    .y_new_i (y_cur),
    .rd_o    (hist)
  );

  abm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .hist_i       (hist),
    .x_o          (x_cur),
    .y_o          (y_cur),
    .sample_out_o (sample_out_o)
  );

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("Input was not stalled after a sample transfer.");

  a_result_from_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("A result appeared without a sample in progress.");

endmodule

`default_nettype wire

// ===== rtl/abm_hist.sv =====
// Per-channel filter history: the last two inputs and outputs of each channel.
// Depends on abm_pkg.
`default_nettype none

module abm_hist
  import abm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ctrl_t                         ctrl_i,
  input  wire logic [CH_BITS-1:0]            chan_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x_new_i,
  input  wire logic signed [SAMPLE_BITS-1:0] y_new_i,
  output hist_t                              rd_o
);

  logic [CH_BITS-1:0]            chan_q;
  logic signed [SAMPLE_BITS-1:0] x1_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x2_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
    end else if (ctrl_i.start) begin
      chan_q <= chan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (ctrl_i.hist_we) begin
      x2_q[chan_q] <= x1_q[chan_q];
      x1_q[chan_q] <= x_new_i;
      y2_q[chan_q] <= y1_q[chan_q];
      y1_q[chan_q] <= y_new_i;
    end
  end

  always_comb begin
    rd_o.x1 = x1_q[chan_q];
    rd_o.x2 = x2_q[chan_q];
    rd_o.y1 = y1_q[chan_q];
    rd_o.y2 = y2_q[chan_q];
  end

endmodule

`default_nettype wire

// ===== rtl/abm_dp.sv =====
// Datapath: configuration registers, the shared multiplier with its product
// register, the accumulator and the result registers. Depends on abm_pkg.
`default_nettype none

module abm_dp
  import abm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ctrl_t                         ctrl_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  wire hist_t                         hist_i,
  output logic signed [SAMPLE_BITS-1:0]      x_o,
  output logic signed [SAMPLE_BITS-1:0]      y_o,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o
);

  logic signed [COEF_BITS-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [GAIN_BITS-1:0]          gain_q;
  logic [MIX_BITS-1:0]           wet_q;
  logic signed [SAMPLE_BITS-1:0] x_q, y_q, out_q;
  logic signed [MB_BITS-1:0]     shaped_q, shaped_d;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [ACC_BITS-1:0]    acc_q, acc_d, prod_ext;
  logic signed [MA_BITS-1:0]     opa;
  logic signed [MB_BITS-1:0]     opb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= '0;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      gain_q <= GAIN_RESET;
      wet_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_B0:  b0_q   <= cfg_data_i[COEF_BITS-1:0];
        CFG_B1:  b1_q   <= cfg_data_i[COEF_BITS-1:0];
        CFG_B2:  b2_q   <= cfg_data_i[COEF_BITS-1:0];
        CFG_A1:  a1_q   <= cfg_data_i[COEF_BITS-1:0];
        CFG_A2:  a2_q   <= cfg_data_i[COEF_BITS-1:0];
        CFG_DRY: gain_q <= cfg_data_i[GAIN_BITS-1:0];
        CFG_WET: wet_q  <= cfg_data_i[MIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctrl_i.op)
      OP_B0X: begin
        opa = b0_q;
        opb = {x_q[SAMPLE_BITS-1], x_q};
      end
      OP_B1X1: begin
        opa = b1_q;
        opb = {hist_i.x1[SAMPLE_BITS-1], hist_i.x1};
      end
      OP_B2X2: begin
        opa = b2_q;
        opb = {hist_i.x2[SAMPLE_BITS-1], hist_i.x2};
      end
      OP_A1Y1: begin
        opa = a1_q;
        opb = {hist_i.y1[SAMPLE_BITS-1], hist_i.y1};
      end
      OP_A2Y2: begin
        opa = a2_q;
        opb = {hist_i.y2[SAMPLE_BITS-1], hist_i.y2};
      end
      OP_XG: begin
        opa = {{(MA_BITS-GAIN_BITS){1'b0}}, gain_q};
        opb = {x_q[SAMPLE_BITS-1], x_q};
      end
      OP_YY: begin
        opa = {{(MA_BITS-SAMPLE_BITS){y_q[SAMPLE_BITS-1]}}, y_q};
        opb = {y_q[SAMPLE_BITS-1], y_q};
      end
      OP_SW: begin
        opa = {{(MA_BITS-MIX_BITS){1'b0}}, wet_q};
        opb = shaped_q;
      end
      default: begin
        opa = b0_q;
        opb = {x_q[SAMPLE_BITS-1], x_q};
      end
    endcase
  end

  assign prod_ext = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

  always_comb begin
    case (ctrl_i.acc)
      ACC_FILT_INIT: acc_d = RND_FILT;
      ACC_ADD:       acc_d = acc_q + prod_ext;
      ACC_SUB:       acc_d = acc_q - prod_ext;
      ACC_MIX_INIT:  acc_d = prod_ext + RND_MIX;
      ACC_ADD_WET:   acc_d = acc_q + (prod_ext <<< WET_SHIFT);
      default:       acc_d = acc_q;
    endcase
  end

  assign shaped_d = {y_q[SAMPLE_BITS-1], y_q}
                  + {2'b00, prod_q[2*SAMPLE_BITS-2:SAMPLE_BITS]};

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    acc_q  <= acc_d;
    if (ctrl_i.start) begin
      x_q <= sample_in_i;
    end
    if (ctrl_i.ld_y) begin
      y_q <= sat_sample(acc_q >>> COEF_FRAC);
    end
    if (ctrl_i.ld_shaped) begin
      shaped_q <= shaped_d;
    end
    if (ctrl_i.ld_out) begin
      out_q <= sat_sample(acc_q >>> MIX_FRAC);
    end
  end

  assign x_o          = x_q;
  assign y_o          = y_q;
  assign sample_out_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/abm_seq.sv =====
// Sequencer: steps one sample through the shared multiplier and owns the
// input stall and the output valid. Depends on abm_pkg.
`default_nettype none

module abm_seq
  import abm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output ctrl_t     ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '{start: 1'b0, op: OP_B0X, acc: ACC_HOLD, ld_y: 1'b0,
                hist_we: 1'b0, ld_shaped: 1'b0, ld_out: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          ctrl_o.acc   = ACC_FILT_INIT;
          state_d      = ST_B0;
        end
      end
      ST_B0: begin
        ctrl_o.op = OP_B0X;
        state_d   = ST_B1;
      end
      ST_B1: begin
        ctrl_o.op  = OP_B1X1;
        ctrl_o.acc = ACC_ADD;
        state_d    = ST_B2;
      end
      ST_B2: begin
        ctrl_o.op  = OP_B2X2;
        ctrl_o.acc = ACC_ADD;
        state_d    = ST_A1;
      end
      ST_A1: begin
        ctrl_o.op  = OP_A1Y1;
        ctrl_o.acc = ACC_ADD;
        state_d    = ST_A2;
      end
      ST_A2: begin
        ctrl_o.op  = OP_A2Y2;
        ctrl_o.acc = ACC_SUB;
        state_d    = ST_XG;
      end
      ST_XG: begin
        ctrl_o.op  = OP_XG;
        ctrl_o.acc = ACC_SUB;
        state_d    = ST_Y;
      end
      ST_Y: begin
        ctrl_o.acc  = ACC_MIX_INIT;
        ctrl_o.ld_y = 1'b1;
        state_d     = ST_YY;
      end
      ST_YY: begin
        ctrl_o.op      = OP_YY;
        ctrl_o.hist_we = 1'b1;
        state_d        = ST_SH;
      end
      ST_SH: begin
        ctrl_o.ld_shaped = 1'b1;
        state_d          = ST_SW;
      end
      ST_SW: begin
        ctrl_o.op = OP_SW;
        state_d   = ST_MIX;
      end
      ST_MIX: begin
        ctrl_o.acc = ACC_ADD_WET;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (!(out_valid_q && out_stall_i)) begin
          ctrl_o.ld_out = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_o.ld_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
